// File: hw/rtl/chained_hash_key_value_store_defines.svh
// Assertion macros used by the store's top-level RTL file
`ifndef CHAINED_HASH_KEY_VALUE_STORE_DEFINES_SVH
`define CHAINED_HASH_KEY_VALUE_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted
`define CHKV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define CHKV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHKV_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHKV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/chkv_pkg.sv
package chkv_pkg;

  // Sizes of the store
  localparam int MAX_BUCKETS = 64;
  localparam int POOL_NODES  = 256;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int BC_W    = 7;
  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int PTR_W   = $clog2(POOL_NODES + 1);
  localparam int DCNT_W  = $clog2(KEY_W);

  // Operation codes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } chkv_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic                    status;
  } chkv_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic bkt_calc;
    logic head_rd;
    logic head_load;
    logic node_rd;
    logic node_adv;
    logic finish_hit;
    logic finish_miss;
  } chkv_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
    logic cur_null;
    logic key_match;
  } chkv_sts_t;

endpackage

// File: hw/rtl/chkv_dp.sv
module chkv_dp import chkv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [BC_W-1:0] cfg_data,
  input  chkv_in_t        in_data,
  input  chkv_cmd_t       cmd,
  output chkv_sts_t       sts,
  output logic            out_valid,
  output chkv_out_t       out_data
);

  // Configuration and control state
  logic [BC_W-1:0]        bc_r;
  logic [PTR_W-1:0]       used_r;
  logic [MAX_BUCKETS-1:0] head_vld_r;
  logic                   out_valid_r;

  // Transaction registers
  logic                   mode_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic                   neg_r;
  logic [KEY_W-1:0]       dvd_r;
  logic [BC_W-1:0]        rem_r;
  logic [DCNT_W-1:0]      cnt_r;
  logic [BKT_W-1:0]       bkt_r;
  logic [PTR_W-1:0]       head_q_r;
  logic                   head_vq_r;
  logic [PTR_W-1:0]       head_r;
  logic [PTR_W-1:0]       cur_r;
  logic [KEY_W-1:0]       nkey_q_r;
  logic [VAL_W-1:0]       nval_q_r;
  logic [PTR_W-1:0]       nlink_q_r;
  chkv_out_t              out_data_r;

  // Storage
  logic [PTR_W-1:0]       head_mem_r  [MAX_BUCKETS];
  logic [KEY_W-1:0]       node_key_r  [POOL_NODES];
  logic [VAL_W-1:0]       node_val_r  [POOL_NODES];
  logic [PTR_W-1:0]       node_link_r [POOL_NODES];

  logic [BC_W-1:0]        n_eff;
  logic [BC_W:0]          trial;
  logic [BC_W-1:0]        rem_nxt;
  logic [BKT_W-1:0]       bkt_nxt;
  logic [PTR_W-1:0]       cur_dec;
  logic [NODE_W-1:0]      cur_idx;
  logic [NODE_W-1:0]      new_idx;
  logic                   pool_full;
  logic                   do_insert;
  logic                   do_update;

  // Divisor clamped into 1 .. MAX_BUCKETS
  always_comb begin
    if (bc_r == '0) begin
      n_eff = BC_W'(1);
    end else if (bc_r > BC_W'(MAX_BUCKETS)) begin
      n_eff = BC_W'(MAX_BUCKETS);
    end else begin
      n_eff = bc_r;
    end
  end

  // One restoring step of |key| mod n
  assign trial   = {rem_r, dvd_r[KEY_W-1]};
  assign rem_nxt = (trial >= {1'b0, n_eff}) ? BC_W'(trial - {1'b0, n_eff}) : BC_W'(trial);

  // Negative keys wrap a nonzero remainder back into range
  assign bkt_nxt = (neg_r && rem_r != '0) ? BKT_W'(n_eff - rem_r) : BKT_W'(rem_r);

  assign cur_dec   = cur_r - PTR_W'(1);
  assign cur_idx   = cur_dec[NODE_W-1:0];
  assign new_idx   = used_r[NODE_W-1:0];
  assign pool_full = (used_r == PTR_W'(POOL_NODES));
  assign do_insert = cmd.finish_miss && mode_r == MODE_PUT && !pool_full;
  assign do_update = cmd.finish_hit && mode_r == MODE_PUT;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= BC_W'(MAX_BUCKETS);
      used_r      <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bc_r <= cfg_data;
      end
      if (do_insert) begin
        used_r            <= used_r + PTR_W'(1);
        head_vld_r[bkt_r] <= 1'b1;
      end
      out_valid_r <= cmd.finish_hit || cmd.finish_miss;
    end
  end

  // Transaction load, divider and chain pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      key_r  <= in_data.key;
      val_r  <= in_data.value;
      neg_r  <= in_data.key[KEY_W-1];
      dvd_r  <= in_data.key[KEY_W-1] ? (KEY_W'(0) - in_data.key) : in_data.key;
      rem_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
      cnt_r <= cnt_r + DCNT_W'(1);
    end
    if (cmd.bkt_calc) begin
      bkt_r <= bkt_nxt;
    end
    if (cmd.head_load) begin
      cur_r  <= head_vq_r ? head_q_r : '0;
      head_r <= head_vq_r ? head_q_r : '0;
    end
    if (cmd.node_adv) begin
      cur_r <= nlink_q_r;
    end
  end

  // Bucket head memory
  always_ff @(posedge clk) begin
    if (do_insert) begin
      head_mem_r[bkt_r] <= used_r + PTR_W'(1);
    end
    if (cmd.head_rd) begin
      head_q_r  <= head_mem_r[bkt_r];
      head_vq_r <= head_vld_r[bkt_r];
    end
  end

  // Node key and link memories
  always_ff @(posedge clk) begin
    if (do_insert) begin
      node_key_r[new_idx]  <= key_r;
      node_link_r[new_idx] <= head_r;
    end
    if (cmd.node_rd) begin
      nkey_q_r  <= node_key_r[cur_idx];
      nlink_q_r <= node_link_r[cur_idx];
    end
  end

  // Node value memory
  always_ff @(posedge clk) begin
    if (do_insert) begin
      node_val_r[new_idx] <= val_r;
    end else if (do_update) begin
      node_val_r[cur_idx] <= val_r;
    end
    if (cmd.node_rd) begin
      nval_q_r <= node_val_r[cur_idx];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      out_data_r.read_value <= (mode_r == MODE_GET) ? nval_q_r : '0;
      out_data_r.found      <= 1'b1;
      out_data_r.status     <= ST_OK;
    end else if (cmd.finish_miss) begin
      out_data_r.read_value <= (mode_r == MODE_GET) ? '1 : '0;
      out_data_r.found      <= 1'b0;
      out_data_r.status     <= (mode_r == MODE_PUT && pool_full) ? ST_FULL : ST_OK;
    end
  end

  assign sts.div_last  = (cnt_r == DCNT_W'(KEY_W - 1));
  assign sts.cur_null  = (cur_r == '0);
  assign sts.key_match = (nkey_q_r == key_r);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// File: hw/rtl/chkv_ctrl.sv
module chkv_ctrl import chkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  chkv_sts_t sts,
  output logic      busy,
  output chkv_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_BKT   = 7'b0000100,
    S_HEAD  = 7'b0001000,
    S_HLOAD = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_CMP   = 7'b1000000
  } chkv_state_t;

  chkv_state_t state_r;
  chkv_state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_BKT;
        end
      end
      S_BKT: begin
        cmd.bkt_calc = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HLOAD;
      end
      S_HLOAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = S_PROBE;
      end
      S_PROBE: begin
        // end of chain: key absent
        if (sts.cur_null) begin
          cmd.finish_miss = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.node_adv = 1'b1;
          state_nxt    = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hw/rtl/chained_hash_key_value_store.sv
// Sequence: accept (S_IDLE), restoring modulo (S_DIV), bucket (S_BKT), head read (S_HEAD,
//   S_HLOAD), then S_PROBE and S_CMP for each chain node; the result strobe is registered.
// Throughput: one transaction at a time, start taken again in the strobe cycle.
// Reset (rst_n, synchronous): empties all chains, zeroes the node count and sets
//   bucket_count to 64; no clearing pass. The receiver cannot stall results.
`include "chained_hash_key_value_store_defines.svh"

module chained_hash_key_value_store import chkv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  chkv_in_t        in_data,
  output logic            out_valid,
  output chkv_out_t       out_data,
  input  logic            cfg_we,
  input  logic [BC_W-1:0] cfg_data
);

  chkv_cmd_t cmd;
  chkv_sts_t sts;

  // Sequencer
  chkv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Modulo unit, tables and result register
  chkv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result only closes a transaction that was in flight
  `CHKV_ASSERT(a_out_after_work, clk, rst_n, out_valid |-> $past(busy), "result strobe without transaction in flight")
  // An accepted transaction keeps the block busy
  `CHKV_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  // Strobe lasts one cycle
  `CHKV_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe held over two cycles")
  // Reset leaves no result pending
  `CHKV_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid && !busy, "activity right after reset")

endmodule

// File: test/tb_top.sv
module tb_top import chkv_pkg::*; ();

  // Timing budget: a miss that walks a full-length chain, plus slack
  localparam int WORST_LATENCY = 38 + 2 * POOL_NODES;
  localparam int TAIL_CYCLES   = WORST_LATENCY + 16;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int MAX_PRINTS    = 100;

  localparam logic [KEY_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] WORD_NEG = 32'hffff_ffff;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  chkv_in_t        in_data;
  logic            out_valid;
  chkv_out_t       out_data;
  logic            cfg_we;
  logic [BC_W-1:0] cfg_data;

  chained_hash_key_value_store uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 4-unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the store
  logic [BC_W-1:0]   shadow_buckets;
  logic [PTR_W-1:0]  shadow_heads [MAX_BUCKETS];
  logic [KEY_W-1:0]  shadow_keys  [POOL_NODES];
  logic [VAL_W-1:0]  shadow_vals  [POOL_NODES];
  logic [PTR_W-1:0]  shadow_links [POOL_NODES];
  logic [PTR_W-1:0]  shadow_used;
  logic [KEY_W-1:0]  stored_keys[$];

  chkv_out_t expected_results[$];

  int mismatch_count;
  int results_seen;
  int puts_sent;
  int gets_sent;
  int hit_count;
  int refused_count;
  int cfg_writes;
  int cycle_count;

  // Sender pacing
  int burst_left;
  bit steady;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_seen);
    mismatch_count++;
  endtask

  // Apply one transaction to the shadow store and return its expected result
  function automatic chkv_out_t apply_to_store(input chkv_in_t item);
    chkv_out_t        res;
    longint           k;
    longint           n;
    longint           r;
    logic [BKT_W-1:0] b;
    int unsigned      steps;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] hit;
    k = longint'($signed(item.key));
    n = (shadow_buckets == 0) ? 1 :
        (shadow_buckets > MAX_BUCKETS) ? MAX_BUCKETS : longint'(shadow_buckets);
    r = k % n;
    if (r < 0) r += n;
    b = BKT_W'(r);
    // chain walk, newest node first
    cur = shadow_heads[b];
    hit = '0;
    steps = 0;
    while (cur != 0 && cur <= shadow_used && steps < POOL_NODES && hit == 0) begin
      if (shadow_keys[NODE_W'(cur - 1'b1)] == item.key) hit = cur;
      else begin
        cur = shadow_links[NODE_W'(cur - 1'b1)];
        steps++;
      end
    end
    res.read_value = '0;
    res.found = 1'b0;
    res.status = ST_OK;
    if (item.mode == MODE_GET) begin
      gets_sent++;
      if (hit != 0) begin
        res.read_value = shadow_vals[NODE_W'(hit - 1'b1)];
        res.found = 1'b1;
        hit_count++;
      end else begin
        res.read_value = '1;
      end
    end else begin
      puts_sent++;
      if (hit != 0) begin
        shadow_vals[NODE_W'(hit - 1'b1)] = item.value;
        res.found = 1'b1;
        hit_count++;
      end else if (shadow_used >= POOL_NODES) begin
        res.status = ST_FULL;
        refused_count++;
      end else begin
        shadow_keys[NODE_W'(shadow_used)]  = item.key;
        shadow_vals[NODE_W'(shadow_used)]  = item.value;
        shadow_links[NODE_W'(shadow_used)] = shadow_heads[b];
        shadow_heads[b] = shadow_used + 1'b1;
        shadow_used = shadow_used + 1'b1;
        stored_keys.push_back(item.key);
      end
    end
    return res;
  endfunction

  // Send one transaction, with burst/gap pacing
  task automatic send_item(input chkv_in_t item);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_to_store(item));
  endtask

  task automatic put_kv(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
    chkv_in_t item;
    item.mode  = MODE_PUT;
    item.key   = key;
    item.value = value;
    send_item(item);
  endtask

  task automatic get_k(input logic [KEY_W-1:0] key);
    chkv_in_t item;
    item.mode  = MODE_GET;
    item.key   = key;
    item.value = $urandom;
    send_item(item);
  endtask

  // Hold off the sender until nothing is outstanding
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [BC_W-1:0] count);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_buckets = count;
    cfg_writes++;
  endtask

  // About half the time a key already stored, else small, negative, extreme and random ones
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && stored_keys.size() > 0)
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    case (sel)
      6: return 32'($urandom_range(0, 200));
      7: return 32'(0) - 32'($urandom_range(1, 200));
      8: begin
        case ($urandom_range(0, 3))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return WORD_NEG;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_NEG;
      default: return '0;
    endcase
  endfunction

  // Empty store, extreme keys and values, update, negative wrap
  task automatic test_empty_and_extremes();
    get_k('0);
    put_kv(WORD_MIN, WORD_MAX);
    put_kv(WORD_MAX, WORD_MIN);
    put_kv('0, '0);
    put_kv(WORD_NEG, WORD_NEG);
    get_k(WORD_MIN);
    get_k(WORD_MAX);
    get_k('0);
    get_k(WORD_NEG);
    get_k(32'd64);
    put_kv(32'd64, 32'h1234_5678);
    put_kv('0, 32'hdead_beef);
    get_k('0);
    put_kv(32'hffff_ffbf, 32'h0bad_cafe);
    get_k(32'hffff_ffbf);
    get_k(32'd64);
  endtask

  // Divisor 0 and above range, and rehash with data in place
  task automatic test_bucket_count_limits();
    write_buckets('0);
    get_k(WORD_MIN);
    get_k(WORD_MAX);
    put_kv(32'd5, 32'h5555_aaaa);
    write_buckets(7'h7f);
    get_k(32'd5);
    put_kv(32'd5, 32'haaaa_5555);
    write_buckets(7'd1);
    get_k(32'd5);
    write_buckets(7'd64);
  endtask

  task automatic test_random_mix(input logic [BC_W-1:0] count, input int items,
                                 input int put_pct, input bit no_idle);
    chkv_in_t item;
    write_buckets(count);
    steady = no_idle;
    burst_left = 0;
    for (int i = 0; i < items; i++) begin
      item.mode  = ($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_GET;
      item.key   = pick_key();
      item.value = pick_value();
      send_item(item);
      // occasional full stop mid-stream
      if ($urandom_range(0, 49) == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  // Fill the node pool with fresh keys
  task automatic test_pool_exhaustion();
    write_buckets(7'd64);
    while (shadow_used < POOL_NODES) put_kv($urandom, pick_value());
    drain_results();
  endtask

  // Refused puts of new keys, accepted updates of stored ones
  task automatic test_full_pool_traffic(input int items);
    chkv_in_t item;
    put_kv($urandom, $urandom);
    put_kv(stored_keys[0], $urandom);
    get_k(stored_keys[0]);
    for (int i = 0; i < items; i++) begin
      item.mode  = ($urandom_range(0, 99) < 70) ? MODE_PUT : MODE_GET;
      item.key   = ($urandom_range(0, 1) == 0) ? $urandom : pick_key();
      item.value = pick_value();
      send_item(item);
    end
  endtask

  // Result checker: strobe is sampled at the edge ending its cycle
  always @(posedge clk) begin : check_results
    chkv_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.read_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.found !== want.found)
          report_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    results_seen   = 0;
    puts_sent      = 0;
    gets_sent      = 0;
    hit_count      = 0;
    refused_count  = 0;
    cfg_writes     = 0;
    burst_left     = 0;
    steady         = 1'b0;
    start    <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    // shadow state after reset
    shadow_buckets = 7'd64;
    shadow_used    = '0;
    foreach (shadow_heads[i]) shadow_heads[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_bucket_count_limits();
    test_random_mix(7'd1, 60, 50, 1'b0);
    test_random_mix(7'd0, 30, 50, 1'b1);
    test_random_mix(7'd64, 200, 45, 1'b0);
    test_random_mix(7'd7, 150, 40, 1'b0);
    test_random_mix(7'h7f, 100, 40, 1'b1);
    test_random_mix(7'd33, 150, 40, 1'b0);
    test_pool_exhaustion();
    test_full_pool_traffic(200);
    test_random_mix(7'd2, 100, 40, 1'b0);
    test_random_mix(7'($urandom_range(3, 63)), 150, 40, 1'b0);

    // let any stray strobe show up before the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", expected_results.size(), '0);

    $display("Ran %0d puts and %0d gets over %0d bucket-count writes, %0d results checked",
             puts_sent, gets_sent, cfg_writes, results_seen);
    $display("Key hits: %0d, refused puts with pool full: %0d, nodes in use: %0d",
             hit_count, refused_count, shadow_used);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
